// ----- hw/rtl/cpdm_pkg.sv -----
// Shared types and constants of the centering-spring PD motor drive.
`default_nettype none

package cpdm_pkg;

  // Fixed scaling of the control law.
  localparam int COUNTS_PER_TURN  = 4096;
  localparam int TICKS_PER_SECOND = 100;
  localparam int RAMP_SPAN        = 90;
  localparam int PWM_TOP          = 1000;
  localparam int ALPHA_Q16        = 19661;

  // Field and datapath widths.
  localparam int ANGLE_W   = 12;
  localparam int POS_W     = 13;
  localparam int DIFF_W    = 14;
  localparam int APOS_W    = 12;
  localparam int VEL_W     = 28;
  localparam int GAIN_W    = 16;
  localparam int DBAND_W   = 8;
  localparam int DRIVE_W   = 10;
  localparam int CMD_W     = 11;
  localparam int MUL_A_W   = 18;
  localparam int MUL_B_W   = 29;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int ACC_W     = 48;
  localparam int MAG_W     = ACC_W - 20;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  // Derived arithmetic constants.
  localparam int VEL_SCALE   = TICKS_PER_SECOND * 256;
  localparam int ALPHA_REST  = 65536 - ALPHA_Q16;
  localparam int RAMP_SHIFT  = 24;
  localparam int RAMP_RECIP  = (2 ** RAMP_SHIFT + RAMP_SPAN - 1) / RAMP_SPAN;
  localparam logic [DRIVE_W-1:0] DRIVE_TOP = DRIVE_W'(PWM_TOP);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ZERO_REF  = 3'd0,
    REG_ENC_NEG   = 3'd1,
    REG_DRV_INV   = 3'd2,
    REG_SPRING    = 3'd3,
    REG_DAMPING   = 3'd4,
    REG_DEADBAND  = 3'd5,
    REG_MIN_DRIVE = 3'd6,
    REG_MAX_DRIVE = 3'd7
  } cfg_idx_e;

  // Controls handed from the sequencer to the output shaping logic.
  typedef struct packed {
    logic kill;       // stale input or inside the deadband
    logic force_pos;  // force is strictly positive, command goes negative
    logic ramp_full;  // excess has reached the full ramp span
    logic invert;     // swap bridge legs
  } shape_ctrl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/cpdm_in_if.sv -----
// Input channel carrying one encoder sample per transfer.
`default_nettype none

interface cpdm_in_if;
  import cpdm_pkg::*;

  logic               valid;
  logic               ready;
  logic [ANGLE_W-1:0] raw_angle;
  logic               angle_fresh;

  modport source (output valid, raw_angle, angle_fresh, input ready);
  modport sink   (input valid, raw_angle, angle_fresh, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/cpdm_out_if.sv -----
// Result channel carrying the drive command and bridge levels per transfer.
`default_nettype none

interface cpdm_out_if;
  import cpdm_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [CMD_W-1:0]   drive_command;
  logic        [DRIVE_W-1:0] leg_a_level;
  logic        [DRIVE_W-1:0] leg_b_level;
  logic signed [POS_W-1:0]   centred_position;

  modport source (output valid, drive_command, leg_a_level, leg_b_level, centred_position,
                  input ready);
  modport sink   (input valid, drive_command, leg_a_level, leg_b_level, centred_position,
                  output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/centering_spring_pd_motor_drive_core.sv -----
// A stale sample goes straight to the finish state. A fresh sample passes the velocity
// filter, spring and damping terms and ramp divide in turn; the filter is skipped on the
// first fresh sample, the force terms inside the deadband. One item at a time: every
// product of the control law goes in turn through the single shared 18x29 multiplier.
// The next input is taken once the sequencer is idle; a finished result waits in the
// output register. Reset is asynchronous: registers to defaults, state and filter cleared.
`default_nettype none

module centering_spring_pd_motor_drive_core (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  cpdm_in_if.sink                                  in_i,
  cpdm_out_if.source                               res_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [cpdm_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [cpdm_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);
  import cpdm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_VEL_T,
    S_VEL_NEW,
    S_VEL_OLD,
    S_FILT,
    S_SPRING,
    S_DAMP,
    S_FORCE,
    S_RAMP,
    S_FINISH
  } state_e;

  // Configuration registers.
  logic [ANGLE_W-1:0] zero_ref_q;
  logic               enc_neg_q;
  logic               drv_inv_q;
  logic [GAIN_W-1:0]  spring_q;
  logic [GAIN_W-1:0]  damping_q;
  logic [DBAND_W-1:0] deadband_q;
  logic [DRIVE_W-1:0] min_drive_q;
  logic [DRIVE_W-1:0] max_drive_q;

  // Sequencer and datapath registers.
  state_e                    state_q;
  logic signed [POS_W-1:0]   pos_q;
  logic signed [POS_W-1:0]   prev_pos_q;
  logic                      prev_valid_q;
  logic signed [DIFF_W-1:0]  diff_q;
  logic signed [VEL_W-1:0]   vel_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic        [APOS_W-1:0]  excess_q;
  logic                      dead_q;
  logic                      stale_q;
  logic                      force_pos_q;
  logic        [MAG_W-1:0]   mag_q;

  // Output register.
  logic                      res_valid_q;
  logic signed [CMD_W-1:0]   res_cmd_q;
  logic        [DRIVE_W-1:0] res_leg_a_q;
  logic        [DRIVE_W-1:0] res_leg_b_q;
  logic signed [POS_W-1:0]   res_pos_q;

  // Configuration writes, masked to the register width.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_ref_q  <= '0;
      enc_neg_q   <= 1'b0;
      drv_inv_q   <= 1'b0;
      spring_q    <= GAIN_W'(3482);
      damping_q   <= GAIN_W'(410);
      deadband_q  <= DBAND_W'(4);
      min_drive_q <= DRIVE_W'(95);
      max_drive_q <= DRIVE_W'(650);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_ZERO_REF:  zero_ref_q  <= cfg_wdata_i[ANGLE_W-1:0];
        REG_ENC_NEG:   enc_neg_q   <= cfg_wdata_i[0];
        REG_DRV_INV:   drv_inv_q   <= cfg_wdata_i[0];
        REG_SPRING:    spring_q    <= cfg_wdata_i[GAIN_W-1:0];
        REG_DAMPING:   damping_q   <= cfg_wdata_i[GAIN_W-1:0];
        REG_DEADBAND:  deadband_q  <= cfg_wdata_i[DBAND_W-1:0];
        REG_MIN_DRIVE: min_drive_q <= cfg_wdata_i[DRIVE_W-1:0];
        REG_MAX_DRIVE: max_drive_q <= cfg_wdata_i[DRIVE_W-1:0];
        default: ;
      endcase
    end
  end

  // Shortest wrapped difference from the zero reference.
  localparam logic signed [POS_W-1:0] HALF_TURN = POS_W'(COUNTS_PER_TURN / 2);
  localparam logic signed [POS_W-1:0] FULL_TURN = POS_W'(COUNTS_PER_TURN);

  logic signed [POS_W-1:0]  raw_diff;
  logic signed [POS_W-1:0]  wrapped;
  logic signed [POS_W-1:0]  pos_new;
  logic signed [POS_W-1:0]  pos_neg;
  logic        [APOS_W-1:0] apos_new;
  logic                     dead_new;

  always_comb begin
    raw_diff = $signed({1'b0, in_i.raw_angle}) - $signed({1'b0, zero_ref_q});
    if (raw_diff > HALF_TURN) begin
      wrapped = raw_diff - FULL_TURN;
    end else if (raw_diff < -HALF_TURN) begin
      wrapped = raw_diff + FULL_TURN;
    end else begin
      wrapped = raw_diff;
    end
    pos_new  = enc_neg_q ? -wrapped : wrapped;
    pos_neg  = -pos_new;
    apos_new = pos_new[POS_W-1] ? pos_neg[APOS_W-1:0] : pos_new[APOS_W-1:0];
    dead_new = (apos_new <= APOS_W'(deadband_q));
  end

  // Shared multiplier and its operand selection.
  logic                       mul_en;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]   prod;

  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    case (state_q)
      S_VEL_T: begin
        mul_en = 1'b1;
        mul_a  = MUL_A_W'(VEL_SCALE);
        mul_b  = {{(MUL_B_W-DIFF_W){diff_q[DIFF_W-1]}}, diff_q};
      end
      S_VEL_NEW: begin
        mul_en = 1'b1;
        mul_a  = MUL_A_W'(ALPHA_Q16);
        mul_b  = prod[MUL_B_W-1:0];
      end
      S_VEL_OLD: begin
        mul_en = 1'b1;
        mul_a  = MUL_A_W'(ALPHA_REST);
        mul_b  = {{(MUL_B_W-VEL_W){vel_q[VEL_W-1]}}, vel_q};
      end
      S_SPRING: begin
        mul_en = 1'b1;
        mul_a  = $signed({{(MUL_A_W-GAIN_W){1'b0}}, spring_q});
        mul_b  = {{(MUL_B_W-POS_W){pos_q[POS_W-1]}}, pos_q};
      end
      S_DAMP: begin
        mul_en = 1'b1;
        mul_a  = $signed({{(MUL_A_W-GAIN_W){1'b0}}, damping_q});
        mul_b  = {{(MUL_B_W-VEL_W){vel_q[VEL_W-1]}}, vel_q};
      end
      S_FORCE: begin
        // Ramp numerator: minimum drive times the excess over the deadband.
        mul_en = 1'b1;
        mul_a  = $signed({{(MUL_A_W-DRIVE_W){1'b0}}, min_drive_q});
        mul_b  = $signed({{(MUL_B_W-APOS_W){1'b0}}, excess_q});
      end
      S_RAMP: begin
        // Division by the ramp span as a multiply by its scaled reciprocal.
        mul_en = 1'b1;
        mul_a  = $signed({1'b0, prod[MUL_A_W-2:0]});
        mul_b  = MUL_B_W'(RAMP_RECIP);
      end
      default: ;
    endcase
  end

  cpdm_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // Filter update and force accumulation around the product register.
  localparam logic signed [ACC_W-1:0] VEL_MAX_W = ACC_W'(2 ** (VEL_W - 1) - 1);
  localparam logic signed [ACC_W-1:0] VEL_MIN_W = -ACC_W'(2 ** (VEL_W - 1));
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(32768);

  logic signed [ACC_W-1:0] prod_ext;
  logic signed [ACC_W-1:0] filt_sum;
  logic signed [ACC_W-1:0] filt_shift;
  logic signed [VEL_W-1:0] vel_new;
  logic signed [ACC_W-1:0] force_sum;
  logic signed [ACC_W-1:0] force_abs;

  always_comb begin
    prod_ext   = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
    filt_sum   = acc_q + prod_ext + ROUND_HALF;
    filt_shift = filt_sum >>> 16;
    if (filt_shift > VEL_MAX_W) begin
      vel_new = VEL_MAX_W[VEL_W-1:0];
    end else if (filt_shift < VEL_MIN_W) begin
      vel_new = VEL_MIN_W[VEL_W-1:0];
    end else begin
      vel_new = filt_shift[VEL_W-1:0];
    end
    force_sum = acc_q + prod_ext;
    force_abs = force_sum[ACC_W-1] ? -force_sum : force_sum;
  end

  // Output shaping.
  shape_ctrl_t             shape_ctrl;
  logic signed [CMD_W-1:0] shape_cmd;
  logic [DRIVE_W-1:0]      shape_leg_a;
  logic [DRIVE_W-1:0]      shape_leg_b;

  always_comb begin
    shape_ctrl.kill      = stale_q | dead_q;
    shape_ctrl.force_pos = force_pos_q;
    shape_ctrl.ramp_full = (excess_q >= APOS_W'(RAMP_SPAN));
    shape_ctrl.invert    = drv_inv_q;
  end

  cpdm_shape u_shape (
    .ctrl_i      (shape_ctrl),
    .mag_i       (mag_q),
    .ramp_i      (prod[RAMP_SHIFT+DRIVE_W-1:RAMP_SHIFT]),
    .min_drive_i (min_drive_q),
    .max_drive_i (max_drive_q),
    .cmd_o       (shape_cmd),
    .leg_a_o     (shape_leg_a),
    .leg_b_o     (shape_leg_b)
  );

  logic in_xfer;
  logic res_free;

  assign in_xfer  = in_i.valid && in_i.ready;
  assign res_free = !res_valid_q || res_o.ready;

  // Sequencer with its state, datapath and output registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      pos_q        <= '0;
      prev_pos_q   <= '0;
      prev_valid_q <= 1'b0;
      diff_q       <= '0;
      vel_q        <= '0;
      acc_q        <= '0;
      excess_q     <= '0;
      stale_q      <= 1'b0;
      dead_q       <= 1'b0;
      force_pos_q  <= 1'b0;
      mag_q        <= '0;
      res_valid_q  <= 1'b0;
      res_cmd_q    <= '0;
      res_leg_a_q  <= '0;
      res_leg_b_q  <= '0;
      res_pos_q    <= '0;
    end else begin
      // A taken result empties the output register unless a new one is loaded below.
      if (res_valid_q && res_o.ready && (state_q != S_FINISH)) begin
        res_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            if (!in_i.angle_fresh) begin
              stale_q <= 1'b1;
              state_q <= S_FINISH;
            end else begin
              stale_q      <= 1'b0;
              pos_q        <= pos_new;
              diff_q       <= DIFF_W'(pos_new) - DIFF_W'(prev_pos_q);
              prev_pos_q   <= pos_new;
              prev_valid_q <= 1'b1;
              dead_q       <= dead_new;
              excess_q     <= apos_new - APOS_W'(deadband_q);
              if (prev_valid_q) begin
                state_q <= S_VEL_T;
              end else if (dead_new) begin
                state_q <= S_FINISH;
              end else begin
                state_q <= S_SPRING;
              end
            end
          end
        end
        S_VEL_T: begin
          state_q <= S_VEL_NEW;
        end
        S_VEL_NEW: begin
          state_q <= S_VEL_OLD;
        end
        S_VEL_OLD: begin
          acc_q   <= prod_ext;
          state_q <= S_FILT;
        end
        S_FILT: begin
          vel_q   <= vel_new;
          state_q <= dead_q ? S_FINISH : S_SPRING;
        end
        S_SPRING: begin
          state_q <= S_DAMP;
        end
        S_DAMP: begin
          acc_q   <= {prod_ext[ACC_W-9:0], 8'b0};
          state_q <= S_FORCE;
        end
        S_FORCE: begin
          force_pos_q <= !force_sum[ACC_W-1] && (force_sum != '0);
          mag_q       <= force_abs[ACC_W-1:ACC_W-MAG_W];
          state_q     <= S_RAMP;
        end
        S_RAMP: begin
          state_q <= S_FINISH;
        end
        S_FINISH: begin
          if (res_free) begin
            res_valid_q <= 1'b1;
            res_cmd_q   <= shape_cmd;
            res_leg_a_q <= shape_leg_a;
            res_leg_b_q <= shape_leg_b;
            res_pos_q   <= stale_q ? '0 : pos_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_i.ready             = (state_q == S_IDLE);
  assign res_o.valid            = res_valid_q;
  assign res_o.drive_command    = res_cmd_q;
  assign res_o.leg_a_level      = res_leg_a_q;
  assign res_o.leg_b_level      = res_leg_b_q;
  assign res_o.centred_position = res_pos_q;

endmodule

`default_nettype wire

// ----- hw/rtl/cpdm_mul.sv -----
// Shared signed multiplier with a registered product.
`default_nettype none

module cpdm_mul (
  input  wire logic                               clk_i,
  input  wire logic                               en_i,
  input  wire logic signed [cpdm_pkg::MUL_A_W-1:0] a_i,
  input  wire logic signed [cpdm_pkg::MUL_B_W-1:0] b_i,
  output logic signed      [cpdm_pkg::PROD_W-1:0]  p_o
);
  import cpdm_pkg::*;

  logic signed [PROD_W-1:0] p_q;
  logic signed [PROD_W-1:0] p_d;

  // Full-width product of the two operands.
  assign p_d = PROD_W'(a_i) * PROD_W'(b_i);

  // The product is held until the sequencer asks for the next one.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

// ----- hw/rtl/cpdm_shape.sv -----
// Minimum-drive ramp, clamp, sign, inversion and bridge leg split.
`default_nettype none

module cpdm_shape (
  input  wire cpdm_pkg::shape_ctrl_t              ctrl_i,
  input  wire logic        [cpdm_pkg::MAG_W-1:0]   mag_i,
  input  wire logic        [cpdm_pkg::DRIVE_W-1:0] ramp_i,
  input  wire logic        [cpdm_pkg::DRIVE_W-1:0] min_drive_i,
  input  wire logic        [cpdm_pkg::DRIVE_W-1:0] max_drive_i,
  output logic signed      [cpdm_pkg::CMD_W-1:0]   cmd_o,
  output logic             [cpdm_pkg::DRIVE_W-1:0] leg_a_o,
  output logic             [cpdm_pkg::DRIVE_W-1:0] leg_b_o
);
  import cpdm_pkg::*;

  logic        [DRIVE_W-1:0] minimum;
  logic        [MAG_W-1:0]   mag_min;
  logic        [DRIVE_W-1:0] limit;
  logic        [DRIVE_W-1:0] mag_clamped;
  logic signed [CMD_W-1:0]   cmd;
  logic signed [CMD_W-1:0]   eff;
  logic signed [CMD_W-1:0]   eff_neg;

  always_comb begin
    // The minimum grows linearly over the ramp span beyond the deadband.
    minimum = ctrl_i.ramp_full ? min_drive_i : ramp_i;

    // A nonzero magnitude is lifted to the minimum; zero stays zero.
    if ((mag_i != '0) && (mag_i < MAG_W'(minimum))) begin
      mag_min = MAG_W'(minimum);
    end else begin
      mag_min = mag_i;
    end

    // Clamp to the smaller of the programmed maximum and the PWM top.
    limit = (max_drive_i > DRIVE_TOP) ? DRIVE_TOP : max_drive_i;
    if (mag_min > MAG_W'(limit)) begin
      mag_clamped = limit;
    end else begin
      mag_clamped = mag_min[DRIVE_W-1:0];
    end

    // The command opposes the force.
    if (ctrl_i.kill) begin
      cmd = '0;
    end else if (ctrl_i.force_pos) begin
      cmd = -$signed({1'b0, mag_clamped});
    end else begin
      cmd = $signed({1'b0, mag_clamped});
    end

    // Optional direction swap, then split onto the two legs.
    eff     = ctrl_i.invert ? -cmd : cmd;
    eff_neg = -eff;
    leg_a_o = '0;
    leg_b_o = '0;
    if (eff[CMD_W-1]) begin
      leg_b_o = eff_neg[DRIVE_W-1:0];
    end else begin
      leg_a_o = eff[DRIVE_W-1:0];
    end
  end

  assign cmd_o = cmd;

endmodule

`default_nettype wire

// ----- hw/rtl/cpdm_checker.sv -----
// Port-level checks of the motor drive core, bound to its top level.
`default_nettype none

module cpdm_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                in_valid_i,
  input wire logic                                in_ready_i,
  input wire logic                                out_valid_i,
  input wire logic                                out_ready_i,
  input wire logic signed [cpdm_pkg::CMD_W-1:0]   drive_command_i,
  input wire logic        [cpdm_pkg::DRIVE_W-1:0] leg_a_i,
  input wire logic        [cpdm_pkg::DRIVE_W-1:0] leg_b_i
);
  import cpdm_pkg::*;

  logic [CMD_W-1:0] cmd_mag;
  logic [CMD_W-1:0] leg_sum;

  // Magnitude of the command and the combined leg level.
  always_comb begin
    cmd_mag = drive_command_i[CMD_W-1] ? CMD_W'(-drive_command_i) : CMD_W'(drive_command_i);
    leg_sum = {1'b0, leg_a_i} | {1'b0, leg_b_i};
  end

  // One item is worked on at a time: no input right after a transfer.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted while an item is still in work");

  // Only one bridge leg is driven at once.
  a_one_leg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (leg_a_i != '0) |-> (leg_b_i == '0))
    else $error("both bridge legs driven");

  // The driven leg carries the command magnitude.
  a_leg_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (leg_sum == cmd_mag))
    else $error("leg level differs from command magnitude");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(drive_command_i))
    else $error("result changed while stalled");

endmodule

bind centering_spring_pd_motor_drive_core cpdm_checker u_cpdm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (res_o.valid),
  .out_ready_i     (res_o.ready),
  .drive_command_i (res_o.drive_command),
  .leg_a_i         (res_o.leg_a_level),
  .leg_b_i         (res_o.leg_b_level)
);

`default_nettype wire

// ----- bench/cpdm_drive_sb_pkg.sv -----
// Scoreboard class that predicts and checks the drive results of the PD motor drive core.
`timescale 1ns / 1ps

package cpdm_drive_sb_pkg;
  import cpdm_pkg::*;

  // Control-law constants, kept apart from the design package on purpose.
  localparam int     TURN_COUNTS  = 4096;
  localparam int     HALF_TURN    = TURN_COUNTS / 2;
  localparam int     TICK_RATE    = 100;
  localparam int     FILTER_ALPHA = 19661;
  localparam int     RAMP_COUNTS  = 90;
  localparam int     PWM_LIMIT    = 1000;
  localparam longint VEL_HI       = 134217727;
  localparam longint VEL_LO       = -134217728;
  localparam int     PRINT_CAP    = 100;

  // One result as it leaves the block.
  typedef struct packed {
    logic signed [CMD_W-1:0]   command;
    logic        [DRIVE_W-1:0] leg_a;
    logic        [DRIVE_W-1:0] leg_b;
    logic signed [POS_W-1:0]   position;
  } drive_result_t;

  class drive_scoreboard;
    // Register copies.
    logic [ANGLE_W-1:0] zero_ref;
    bit                 enc_negate;
    bit                 drive_inv;
    logic [GAIN_W-1:0]  spring_gain;
    logic [GAIN_W-1:0]  damping_gain;
    logic [DBAND_W-1:0] deadband;
    logic [DRIVE_W-1:0] min_drive;
    logic [DRIVE_W-1:0] max_drive;

    // Controller state.
    int     prev_pos;
    bit     prev_valid;
    longint velocity;

    drive_result_t expected_drive[$];

    int errors;
    int samples;
    int stale_samples;
    int results_seen;
    int in_deadband;
    int ramped;
    int clamped;

    function new();
      zero_ref      = '0;
      enc_negate    = 1'b0;
      drive_inv     = 1'b0;
      spring_gain   = 16'd3482;
      damping_gain  = 16'd410;
      deadband      = 8'd4;
      min_drive     = 10'd95;
      max_drive     = 10'd650;
      prev_pos      = 0;
      prev_valid    = 1'b0;
      velocity      = 0;
      errors        = 0;
      samples       = 0;
      stale_samples = 0;
      results_seen  = 0;
      in_deadband   = 0;
      ramped        = 0;
      clamped       = 0;
    endfunction

    // Mirror a register write; data is cut to the register's width.
    function void set_register(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_ZERO_REF:  zero_ref     = data[ANGLE_W-1:0];
        REG_ENC_NEG:   enc_negate   = data[0];
        REG_DRV_INV:   drive_inv    = data[0];
        REG_SPRING:    spring_gain  = data[GAIN_W-1:0];
        REG_DAMPING:   damping_gain = data[GAIN_W-1:0];
        REG_DEADBAND:  deadband     = data[DBAND_W-1:0];
        REG_MIN_DRIVE: min_drive    = data[DRIVE_W-1:0];
        REG_MAX_DRIVE: max_drive    = data[DRIVE_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_drive.size();
    endfunction

    // Predict the result of one accepted sample and queue it.
    function void note_sample(logic [ANGLE_W-1:0] angle, logic fresh);
      drive_result_t want;
      int            d;
      int            apos;
      int            excess;
      int            cmd;
      int            steer;
      longint        acc;
      longint        torque;
      longint        mag;
      longint        minimum;
      longint        limit;

      want = '0;
      samples++;
      // A stale sample gives all zeros and leaves the state alone.
      if (!fresh) begin
        stale_samples++;
        expected_drive.push_back(want);
        return;
      end

      // Shortest wrapped distance from the centre.
      d = int'(angle) - int'(zero_ref);
      if (d > HALF_TURN) d -= TURN_COUNTS;
      else if (d < -HALF_TURN) d += TURN_COUNTS;
      if (enc_negate) d = -d;

      // First-order velocity filter, skipped on the first fresh tick.
      if (prev_valid) begin
        acc = longint'(FILTER_ALPHA) * longint'(d - prev_pos) * TICK_RATE * 256
            + longint'(65536 - FILTER_ALPHA) * velocity + 64'sd32768;
        acc = acc >>> 16;
        if (acc > VEL_HI) acc = VEL_HI;
        if (acc < VEL_LO) acc = VEL_LO;
        velocity = acc;
      end
      prev_pos   = d;
      prev_valid = 1'b1;

      // Spring and damping law with deadband, minimum ramp and clamp.
      apos = (d < 0) ? -d : d;
      cmd  = 0;
      if (apos <= int'(deadband)) begin
        in_deadband++;
      end else begin
        torque = longint'(spring_gain) * d * 256 + longint'(damping_gain) * velocity;
        mag    = ((torque < 0) ? -torque : torque) / 1048576;
        excess = apos - int'(deadband);
        if (excess >= RAMP_COUNTS) minimum = min_drive;
        else minimum = longint'(min_drive) * excess / RAMP_COUNTS;
        if (mag > 0 && mag < minimum) begin
          mag = minimum;
          ramped++;
        end
        limit = (int'(max_drive) > PWM_LIMIT) ? PWM_LIMIT : int'(max_drive);
        if (mag > limit) begin
          mag = limit;
          clamped++;
        end
        cmd = (torque > 0) ? -int'(mag) : int'(mag);
      end

      // Optional inversion, then the split onto the two bridge legs.
      steer         = drive_inv ? -cmd : cmd;
      want.command  = CMD_W'(cmd);
      want.leg_a    = (steer > 0) ? DRIVE_W'(steer) : '0;
      want.leg_b    = (steer < 0) ? DRIVE_W'(-steer) : '0;
      want.position = POS_W'(d);
      expected_drive.push_back(want);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Compare one result transfer with the oldest prediction.
    task check_result(drive_result_t got);
      drive_result_t want;
      if (expected_drive.size() == 0) begin
        report($sformatf("result with no sample outstanding: command %0d position %0d",
                         got.command, got.position));
        return;
      end
      want = expected_drive.pop_front();
      if (got.command !== want.command)
        report($sformatf("result %0d drive_command got %0d, want %0d",
                         results_seen, got.command, want.command));
      if (got.leg_a !== want.leg_a)
        report($sformatf("result %0d leg_a_level got %0d, want %0d",
                         results_seen, got.leg_a, want.leg_a));
      if (got.leg_b !== want.leg_b)
        report($sformatf("result %0d leg_b_level got %0d, want %0d",
                         results_seen, got.leg_b, want.leg_b));
      if (got.position !== want.position)
        report($sformatf("result %0d centred_position got %0d, want %0d",
                         results_seen, got.position, want.position));
      results_seen++;
    endtask
  endclass

endpackage

// ----- bench/tb_top.sv -----
// Top-level testbench of the centering-spring PD motor drive core.
`timescale 1ns / 1ps

module tb_top;
  import cpdm_pkg::*;
  import cpdm_drive_sb_pkg::*;

  localparam int SETTING_COUNT     = 10;
  localparam int ITEMS_PER_SETTING = 175;
  localparam int STALL_LIMIT       = 2000;
  localparam int DIRECTED_COUNT    = 20;

  // Directed samples as {fresh, angle}, run with the reset settings.
  localparam logic [ANGLE_W:0] DIRECTED [DIRECTED_COUNT] = '{
    {1'b0, 12'd4095},  // stale before any fresh sample
    {1'b1, 12'd0},     // first fresh tick at the centre
    {1'b1, 12'd4},     // on the deadband edge
    {1'b1, 12'd5},     // one count past the deadband, start of the ramp
    {1'b1, 12'd4092},
    {1'b1, 12'd4091},
    {1'b1, 12'd60},
    {1'b0, 12'd2048},  // stale in the middle of a run
    {1'b1, 12'd94},    // ramp fully in
    {1'b1, 12'd2048},  // half a turn, not wrapped
    {1'b1, 12'd2049},  // just past half a turn, wraps negative
    {1'b1, 12'd2047},
    {1'b1, 12'd4095},
    {1'b1, 12'd1},
    {1'b1, 12'h555},
    {1'b1, 12'hAAA},
    {1'b1, 12'd3},     // inside the deadband after a big swing
    {1'b1, 12'd95},
    {1'b1, 12'd95},    // standing still outside the deadband
    {1'b1, 12'd4000}
  };

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  cpdm_in_if  in_ch ();
  cpdm_out_if res_ch ();

  drive_scoreboard sb = new();

  bit                 steady_flow = 1'b0;
  logic [ANGLE_W-1:0] centre = '0;
  int                 stall_cycles = 0;

  centering_spring_pd_motor_drive_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_ch),
    .res_o       (res_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #10 clk_i = ~clk_i;

  // Gap length: mostly none, sometimes a few cycles, rarely a long one.
  function automatic int pick_gap();
    int roll;
    if (steady_flow) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one sample and hold it until the block takes it.
  task automatic send_sample(input logic [ANGLE_W-1:0] angle, input logic fresh);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.raw_angle   <= angle;
    in_ch.angle_fresh <= fresh;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_sample(angle, fresh);
  endtask

  // Write all eight registers for one setting; the block is idle here.
  task automatic apply_setting(input int phase);
    logic [CFG_DATA_W-1:0] vals [8];
    case (phase)
      1: begin
        foreach (vals[i]) vals[i] = '0;
      end
      2: begin
        foreach (vals[i]) vals[i] = '1;
      end
      3: begin
        vals[REG_ZERO_REF]  = 16'd2048;
        vals[REG_ENC_NEG]   = 16'd1;
        vals[REG_DRV_INV]   = 16'd0;
        vals[REG_SPRING]    = 16'd3482;
        vals[REG_DAMPING]   = 16'd410;
        vals[REG_DEADBAND]  = 16'd10;
        vals[REG_MIN_DRIVE] = 16'd1000;
        vals[REG_MAX_DRIVE] = 16'd300;
      end
      4: begin
        vals[REG_ZERO_REF]  = 16'($urandom);
        vals[REG_ENC_NEG]   = 16'd0;
        vals[REG_DRV_INV]   = 16'd1;
        vals[REG_SPRING]    = 16'hFFFF;
        vals[REG_DAMPING]   = 16'd0;
        vals[REG_DEADBAND]  = 16'd0;
        vals[REG_MIN_DRIVE] = 16'd1000;
        vals[REG_MAX_DRIVE] = 16'd1000;
      end
      default: begin
        vals[REG_ZERO_REF]  = 16'($urandom);
        vals[REG_ENC_NEG]   = 16'($urandom);
        vals[REG_DRV_INV]   = 16'($urandom);
        vals[REG_SPRING]    = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                          : 16'($urandom_range(0, 12000));
        vals[REG_DAMPING]   = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                          : 16'($urandom_range(0, 4000));
        vals[REG_DEADBAND]  = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                          : 16'($urandom_range(0, 30));
        vals[REG_MIN_DRIVE] = 16'($urandom_range(0, 1023));
        vals[REG_MAX_DRIVE] = 16'($urandom_range(0, 1023));
      end
    endcase
    for (int i = 0; i < 8; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= cfg_idx_e'(i);
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
      sb.set_register(cfg_idx_e'(i), vals[i]);
    end
    cfg_we_i <= 1'b0;
    centre = vals[REG_ZERO_REF][ANGLE_W-1:0];
  endtask

  // Result side: check each transfer and stall at random.
  initial begin
    int hold;
    hold = 0;
    res_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (res_ch.valid && res_ch.ready)
        sb.check_result(drive_result_t'{res_ch.drive_command, res_ch.leg_a_level,
                                        res_ch.leg_b_level, res_ch.centred_position});
      if (hold > 0) hold--;
      else if ($urandom_range(0, 2) == 0) hold = pick_gap();
      res_ch.ready <= (hold == 0);
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("centering_spring_pd_motor_drive_core test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Stimulus: directed samples, then a trajectory per register setting.
  initial begin
    int                 offset;
    int                 pick;
    logic [ANGLE_W-1:0] angle;
    logic               fresh;

    in_ch.valid       <= 1'b0;
    in_ch.raw_angle   <= '0;
    in_ch.angle_fresh <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[i]) send_sample(DIRECTED[i][ANGLE_W-1:0], DIRECTED[i][ANGLE_W]);

    for (int phase = 0; phase < SETTING_COUNT; phase++) begin
      if (phase > 0) apply_setting(phase);
      steady_flow = ($urandom_range(0, 3) == 0);
      offset = 0;
      repeat (ITEMS_PER_SETTING) begin
        pick  = $urandom_range(0, 99);
        fresh = 1'b1;
        if (pick < 12) begin
          fresh = 1'b0;
          angle = ANGLE_W'($urandom);
        end else if (pick < 20) begin
          angle = ANGLE_W'($urandom);
        end else if (pick < 24) begin
          // Near half a turn away, where the wrap decides the sign.
          angle = centre + ANGLE_W'(HALF_TURN - 2 + $urandom_range(0, 4));
        end else begin
          // Smooth motion around the centre, with an occasional jump.
          if (pick < 30 || offset > 400 || offset < -400)
            offset = int'($urandom_range(0, 600)) - 300;
          else
            offset += int'($urandom_range(0, 40)) - 20;
          angle = centre + ANGLE_W'(offset);
        end
        send_sample(angle, fresh);
      end
      in_ch.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clk_i);
      repeat (12) @(posedge clk_i);
    end

    repeat (20) @(posedge clk_i);
    $display("Covered %0d samples (%0d stale) over %0d register settings, %0d results compared.",
             sb.samples, sb.stale_samples, SETTING_COUNT, sb.results_seen);
    $display("Commands: %0d in the deadband, %0d raised to the ramp minimum, %0d clamped.",
             sb.in_deadband, sb.ramped, sb.clamped);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("centering_spring_pd_motor_drive_core test passed");
    end else begin
      $display("centering_spring_pd_motor_drive_core test failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/cpdm_pkg.sv
hw/rtl/cpdm_in_if.sv
hw/rtl/cpdm_out_if.sv
hw/rtl/cpdm_mul.sv
hw/rtl/cpdm_shape.sv
hw/rtl/centering_spring_pd_motor_drive_core.sv
hw/rtl/cpdm_checker.sv
bench/cpdm_drive_sb_pkg.sv
bench/tb_top.sv
